### sv/touch_drag_tracker_assert.svh
// Assertion macros shared by the touch drag tracker modules.
`ifndef TOUCH_DRAG_TRACKER_ASSERT_SVH
`define TOUCH_DRAG_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tdt_pkg.sv
// Shared constants, command codes and control structs of the touch drag tracker.
package tdt_pkg;

	localparam int MAX_DRAGS_DEF   = 16;
	localparam int COORD_BITS_DEF  = 16;
	localparam int BUTTON_BITS_DEF = 8;

	localparam int CMD_W   = 3;
	localparam int DIST_W  = 17;
	localparam logic [DIST_W-1:0] DIST_RESET = 17'd106;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_MAX_DIST = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_UPDATE = 3'd0,
		CMD_DROP   = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_SET_UI = 3'd3,
		CMD_READ   = 3'd4
	} tdt_cmd_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clear_total;
		logic sweep;
		logic commit_drop;
		logic decide;
		logic merge;
		logic rd_req;
		logic rd_data;
		logic load_out;
	} tdt_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             issue_done;
		logic             pipe_busy;
		logic             hit;
	} tdt_stat_t;

endpackage

### sv/tdt_req_if.sv
// Request channel: one command beat with its event fields.
interface tdt_req_if #(
	parameter int IDX_W       = 4,
	parameter int COORD_BITS  = tdt_pkg::COORD_BITS_DEF,
	parameter int BUTTON_BITS = tdt_pkg::BUTTON_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [tdt_pkg::CMD_W-1:0]     command;
	logic signed [COORD_BITS-1:0]  prev_x;
	logic signed [COORD_BITS-1:0]  prev_y;
	logic signed [COORD_BITS-1:0]  pos_x;
	logic signed [COORD_BITS-1:0]  pos_y;
	logic                          touch_down;
	logic [BUTTON_BITS-1:0]        btn_mask;
	logic                          ui_flag;
	logic [IDX_W-1:0]              read_index;

	modport source (
		output valid, command, prev_x, prev_y, pos_x, pos_y, touch_down,
			btn_mask, ui_flag, read_index,
		input ready
	);
	modport sink (
		input valid, command, prev_x, prev_y, pos_x, pos_y, touch_down,
			btn_mask, ui_flag, read_index,
		output ready
	);
endinterface

### sv/tdt_rsp_if.sv
// Response channel: one result beat per command.
interface tdt_rsp_if #(
	parameter int IDX_W       = 4,
	parameter int CNT_W       = 5,
	parameter int COORD_BITS  = tdt_pkg::COORD_BITS_DEF,
	parameter int BUTTON_BITS = tdt_pkg::BUTTON_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [IDX_W-1:0]              slot;
	logic                          created;
	logic                          table_full;
	logic [CNT_W-1:0]              drag_count;
	logic signed [COORD_BITS-1:0]  entry_x;
	logic signed [COORD_BITS-1:0]  entry_y;
	logic signed [COORD_BITS-1:0]  entry_start_x;
	logic signed [COORD_BITS-1:0]  entry_start_y;
	logic                          entry_pressed;
	logic                          entry_new;
	logic [BUTTON_BITS-1:0]        entry_mask;
	logic                          entry_ui;

	modport source (
		output valid, slot, created, table_full, drag_count, entry_x, entry_y,
			entry_start_x, entry_start_y, entry_pressed, entry_new, entry_mask, entry_ui,
		input ready
	);
	modport sink (
		input valid, slot, created, table_full, drag_count, entry_x, entry_y,
			entry_start_x, entry_start_y, entry_pressed, entry_new, entry_mask, entry_ui,
		output ready
	);
endinterface

### sv/touch_drag_tracker.sv
// Touch drag tracker: keeps an ordered table of up to MAX_DRAGS drags in one RAM and
// answers one result beat per command beat. A new command is taken only when the
// previous one has finished its table work; a finished result waits in the output
// register without holding up the next command. The table has a single read port and
// is walked one entry per cycle. The distance threshold is the register at APB byte
// address 0, 106 after reset; the table needs no clearing pass after reset.
module touch_drag_tracker #(
	parameter int MAX_DRAGS   = tdt_pkg::MAX_DRAGS_DEF,
	parameter int COORD_BITS  = tdt_pkg::COORD_BITS_DEF,
	parameter int BUTTON_BITS = tdt_pkg::BUTTON_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tdt_pkg::PADDR_W-1:0]  paddr,
	input  logic [tdt_pkg::PDATA_W-1:0]  pwdata,
	output logic [tdt_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	tdt_req_if.sink                      req,
	tdt_rsp_if.source                    rsp
);
	localparam int IDX_W = (MAX_DRAGS > 1) ? $clog2(MAX_DRAGS) : 1;
	localparam int CNT_W = $clog2(MAX_DRAGS + 1);

	tdt_pkg::tdt_ctl_t          ctl;
	tdt_pkg::tdt_stat_t         stat;
	logic [tdt_pkg::DIST_W-1:0] max_dist;
	logic                       in_ready;
	logic                       out_valid;

	tdt_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.max_dist (max_dist)
	);

	tdt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.in_ready    (in_ready),
		.out_ready   (rsp.ready),
		.out_valid   (out_valid),
		.stat        (stat),
		.ctl         (ctl)
	);

	tdt_dp #(
		.MAX_DRAGS   (MAX_DRAGS),
		.COORD_BITS  (COORD_BITS),
		.BUTTON_BITS (BUTTON_BITS),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.max_dist      (max_dist),
		.command       (req.command),
		.prev_x        (req.prev_x),
		.prev_y        (req.prev_y),
		.pos_x         (req.pos_x),
		.pos_y         (req.pos_y),
		.touch_down    (req.touch_down),
		.btn_mask      (req.btn_mask),
		.ui_flag       (req.ui_flag),
		.read_index    (req.read_index),
		.slot          (rsp.slot),
		.created       (rsp.created),
		.table_full    (rsp.table_full),
		.drag_count    (rsp.drag_count),
		.entry_x       (rsp.entry_x),
		.entry_y       (rsp.entry_y),
		.entry_start_x (rsp.entry_start_x),
		.entry_start_y (rsp.entry_start_y),
		.entry_pressed (rsp.entry_pressed),
		.entry_new     (rsp.entry_new),
		.entry_mask    (rsp.entry_mask),
		.entry_ui      (rsp.entry_ui)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
endmodule

### sv/tdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### sv/tdt_regs.sv
// APB configuration register block holding the drag distance threshold.
module tdt_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tdt_pkg::PADDR_W-1:0]     paddr,
	input  logic [tdt_pkg::PDATA_W-1:0]     pwdata,
	output logic [tdt_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	output logic [tdt_pkg::DIST_W-1:0]      max_dist
);
	logic [tdt_pkg::DIST_W-1:0] max_dist_q;
	logic                       sel_max_dist;

	assign pready       = 1'b1;
	assign sel_max_dist = (paddr[tdt_pkg::PADDR_W-1:2] == tdt_pkg::REG_MAX_DIST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= tdt_pkg::DIST_RESET;
		end else if (psel && penable && pwrite && pready && sel_max_dist) begin
			max_dist_q <= pwdata[tdt_pkg::DIST_W-1:0];
		end
	end

	assign prdata   = sel_max_dist ? tdt_pkg::PDATA_W'(max_dist_q) : '0;
	assign max_dist = max_dist_q;
endmodule

### sv/tdt_ctrl.sv
// Controller state machine sequencing each command through the datapath.
module tdt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [tdt_pkg::CMD_W-1:0]   req_command,
	output logic                        in_ready,
	input  logic                        out_ready,
	output logic                        out_valid,
	input  tdt_pkg::tdt_stat_t          stat,
	output tdt_pkg::tdt_ctl_t           ctl
);
	`include "touch_drag_tracker_assert.svh"

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SWEEP  = 7'b0000010,
		ST_DECIDE = 7'b0000100,
		ST_MERGE  = 7'b0001000,
		ST_READ   = 7'b0010000,
		ST_RDDATA = 7'b0100000,
		ST_RESP   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.accept = 1'b1;
					case (req_command) inside
						tdt_pkg::CMD_UPDATE, tdt_pkg::CMD_DROP, tdt_pkg::CMD_SET_UI: begin
							state_d = ST_SWEEP;
						end
						tdt_pkg::CMD_CLEAR: begin
							ctl.clear_total = 1'b1;
							state_d         = ST_RESP;
						end
						tdt_pkg::CMD_READ: begin
							state_d = ST_READ;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_SWEEP: begin
				ctl.sweep = 1'b1;
				// Leave once every entry is issued and the compare stages are empty.
				if (stat.issue_done && !stat.pipe_busy) begin
					if (stat.op == tdt_pkg::CMD_UPDATE) begin
						state_d = ST_DECIDE;
					end else begin
						ctl.commit_drop = (stat.op == tdt_pkg::CMD_DROP);
						state_d         = ST_RESP;
					end
				end
			end
			ST_DECIDE: begin
				ctl.decide = 1'b1;
				state_d    = stat.hit ? ST_MERGE : ST_RESP;
			end
			ST_MERGE: begin
				ctl.merge = 1'b1;
				state_d   = ST_RESP;
			end
			ST_READ: begin
				ctl.rd_req = 1'b1;
				state_d    = ST_RDDATA;
			end
			ST_RDDATA: begin
				ctl.rd_data = 1'b1;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TDT_ASSERT_NEXT(a_accept_starts_work, clk, arst_n, req_valid && in_ready, state_q != ST_IDLE, "accepted beat did not leave idle")
	`TDT_ASSERT_SAME(a_out_from_resp, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_RESP, "result raised outside the response state")
	`TDT_ASSERT_SAME(a_merge_after_decide, clk, arst_n, state_q == ST_MERGE, $past(state_q) == ST_DECIDE, "merge entered without a decision")
endmodule

### sv/tdt_dp.sv
// Datapath: drag table RAM, nearest-entry scan, compaction and result registers.
module tdt_dp #(
	parameter int MAX_DRAGS   = tdt_pkg::MAX_DRAGS_DEF,
	parameter int COORD_BITS  = tdt_pkg::COORD_BITS_DEF,
	parameter int BUTTON_BITS = tdt_pkg::BUTTON_BITS_DEF,
	parameter int IDX_W       = (MAX_DRAGS > 1) ? $clog2(MAX_DRAGS) : 1,
	parameter int CNT_W       = $clog2(MAX_DRAGS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tdt_pkg::tdt_ctl_t               ctl,
	output tdt_pkg::tdt_stat_t              stat,
	input  logic [tdt_pkg::DIST_W-1:0]      max_dist,
	input  logic [tdt_pkg::CMD_W-1:0]       command,
	input  logic signed [COORD_BITS-1:0]    prev_x,
	input  logic signed [COORD_BITS-1:0]    prev_y,
	input  logic signed [COORD_BITS-1:0]    pos_x,
	input  logic signed [COORD_BITS-1:0]    pos_y,
	input  logic                            touch_down,
	input  logic [BUTTON_BITS-1:0]          btn_mask,
	input  logic                            ui_flag,
	input  logic [IDX_W-1:0]                read_index,
	output logic [IDX_W-1:0]                slot,
	output logic                            created,
	output logic                            table_full,
	output logic [CNT_W-1:0]                drag_count,
	output logic signed [COORD_BITS-1:0]    entry_x,
	output logic signed [COORD_BITS-1:0]    entry_y,
	output logic signed [COORD_BITS-1:0]    entry_start_x,
	output logic signed [COORD_BITS-1:0]    entry_start_y,
	output logic                            entry_pressed,
	output logic                            entry_new,
	output logic [BUTTON_BITS-1:0]          entry_mask,
	output logic                            entry_ui
);
	`include "touch_drag_tracker_assert.svh"

	localparam int C           = COORD_BITS;
	localparam int OFS_UI      = 0;
	localparam int OFS_FRESH   = 1;
	localparam int OFS_PRESSED = 2;
	localparam int OFS_MASK    = 3;
	localparam int OFS_SY      = OFS_MASK + BUTTON_BITS;
	localparam int OFS_SX      = OFS_SY + C;
	localparam int OFS_LY      = OFS_SX + C;
	localparam int OFS_LX      = OFS_LY + C;
	localparam int EW          = OFS_LX + C;
	localparam int DW          = C + 2;
	localparam int CMPW        = (DW > tdt_pkg::DIST_W) ? DW : tdt_pkg::DIST_W;

	// Latched command and event fields.
	logic [tdt_pkg::CMD_W-1:0] op_q;
	logic [C-1:0]              px_q, py_q, nx_q, ny_q;
	logic                      pressed_q;
	logic [BUTTON_BITS-1:0]    mask_q;
	logic                      ui_q;
	logic [IDX_W-1:0]          ridx_q;

	// Table control.
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] j_q;

	// Scan pipeline and running minimum.
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [DW-1:0]    dist_s2;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [DW-1:0]    best_d_q;

	// Result being built and the output register.
	logic [IDX_W-1:0]       res_slot_q;
	logic                   res_created_q;
	logic                   res_full_q;
	logic [EW-1:0]          res_entry_q;
	logic [IDX_W-1:0]       out_slot_q;
	logic                   out_created_q;
	logic                   out_full_q;
	logic [CNT_W-1:0]       out_count_q;
	logic [EW-1:0]          out_entry_q;

	// RAM ports.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [EW-1:0]    ram_rdata;

	logic          issue;
	logic          hit;
	logic          has_room;
	logic          append;
	logic          keep_entry;
	logic [C:0]    dx, dy, adx, ady;
	logic [DW-1:0] manh_d;
	logic [EW-1:0] new_entry;
	logic [EW-1:0] merged_entry;

	tdt_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_DRAGS),
		.AW    (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign issue    = ctl.sweep && (idx_q < total_q);
	assign has_room = (total_q < CNT_W'(MAX_DRAGS));
	assign hit      = found_q && (!pressed_q || (CMPW'(best_d_q) <= CMPW'(max_dist)));
	assign append   = ctl.decide && !hit && has_room;
	assign keep_entry = vld_s1 && (op_q == tdt_pkg::CMD_DROP) && ram_rdata[OFS_PRESSED];

	assign stat.op         = op_q;
	assign stat.issue_done = (idx_q >= total_q);
	assign stat.pipe_busy  = vld_s1 || vld_s2;
	assign stat.hit        = hit;

	// Manhattan distance from the stored last point to the event's previous point.
	assign dx     = {ram_rdata[OFS_LX+C-1], ram_rdata[OFS_LX +: C]} - {px_q[C-1], px_q};
	assign dy     = {ram_rdata[OFS_LY+C-1], ram_rdata[OFS_LY +: C]} - {py_q[C-1], py_q};
	assign adx    = dx[C] ? (~dx + 1'b1) : dx;
	assign ady    = dy[C] ? (~dy + 1'b1) : dy;
	assign manh_d = {1'b0, adx} + {1'b0, ady};

	assign new_entry    = {nx_q, ny_q, nx_q, ny_q, mask_q, pressed_q, 1'b1, 1'b0};
	assign merged_entry = {nx_q, ny_q, ram_rdata[OFS_SX +: C], ram_rdata[OFS_SY +: C],
		mask_q, pressed_q, 1'b0, ram_rdata[OFS_UI]};

	always_comb begin
		ram_re = issue || ctl.decide || ctl.rd_req;
		if (ctl.decide) begin
			ram_raddr = best_idx_q;
		end else if (ctl.rd_req) begin
			ram_raddr = ridx_q;
		end else begin
			ram_raddr = idx_q[IDX_W-1:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = ram_rdata;
		if (append) begin
			ram_we    = 1'b1;
			ram_waddr = total_q[IDX_W-1:0];
			ram_wdata = new_entry;
		end else if (ctl.merge) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = merged_entry;
		end else if (keep_entry) begin
			// Compaction: surviving entries move down to the write pointer.
			ram_we    = 1'b1;
			ram_waddr = j_q[IDX_W-1:0];
		end else if (vld_s1 && (op_q == tdt_pkg::CMD_SET_UI)) begin
			ram_we            = 1'b1;
			ram_wdata[OFS_UI] = ui_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			idx_q   <= '0;
			j_q     <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (ctl.clear_total) begin
				total_q <= '0;
			end else if (ctl.commit_drop) begin
				total_q <= j_q;
			end else if (append) begin
				total_q <= total_q + CNT_W'(1);
			end

			if (ctl.accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end

			if (ctl.accept) begin
				j_q <= '0;
			end else if (keep_entry) begin
				j_q <= j_q + CNT_W'(1);
			end

			vld_s1 <= issue;
			vld_s2 <= vld_s1 && (op_q == tdt_pkg::CMD_UPDATE);

			if (ctl.accept) begin
				found_q <= 1'b0;
			end else if (vld_s2) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q[IDX_W-1:0];
		idx_s2  <= idx_s1;
		dist_s2 <= manh_d;

		// The first entry keeps a tie, so only a strictly smaller distance wins.
		if (vld_s2 && (!found_q || (dist_s2 < best_d_q))) begin
			best_d_q   <= dist_s2;
			best_idx_q <= idx_s2;
		end

		if (ctl.accept) begin
			op_q          <= command;
			px_q          <= prev_x;
			py_q          <= prev_y;
			nx_q          <= pos_x;
			ny_q          <= pos_y;
			pressed_q     <= touch_down;
			mask_q        <= btn_mask;
			ui_q          <= ui_flag;
			ridx_q        <= read_index;
			res_slot_q    <= '0;
			res_created_q <= 1'b0;
			res_full_q    <= 1'b0;
			res_entry_q   <= '0;
		end else if (ctl.decide && !hit) begin
			if (has_room) begin
				res_slot_q    <= total_q[IDX_W-1:0];
				res_created_q <= 1'b1;
			end else begin
				res_full_q <= 1'b1;
			end
		end else if (ctl.merge) begin
			res_slot_q <= best_idx_q;
		end else if (ctl.rd_data) begin
			res_slot_q <= ridx_q;
			if (CNT_W'(ridx_q) < total_q) begin
				res_entry_q <= ram_rdata;
			end
		end

		if (ctl.load_out) begin
			out_slot_q    <= res_slot_q;
			out_created_q <= res_created_q;
			out_full_q    <= res_full_q;
			out_count_q   <= total_q;
			out_entry_q   <= res_entry_q;
		end
	end

	assign slot          = out_slot_q;
	assign created       = out_created_q;
	assign table_full    = out_full_q;
	assign drag_count    = out_count_q;
	assign entry_x       = out_entry_q[OFS_LX +: C];
	assign entry_y       = out_entry_q[OFS_LY +: C];
	assign entry_start_x = out_entry_q[OFS_SX +: C];
	assign entry_start_y = out_entry_q[OFS_SY +: C];
	assign entry_mask    = out_entry_q[OFS_MASK +: BUTTON_BITS];
	assign entry_pressed = out_entry_q[OFS_PRESSED];
	assign entry_new     = out_entry_q[OFS_FRESH];
	assign entry_ui      = out_entry_q[OFS_UI];

	`TDT_ASSERT_SAME(a_total_bounded, clk, arst_n, 1'b1, total_q <= CNT_W'(MAX_DRAGS), "drag count above table depth")
	`TDT_ASSERT_SAME(a_s2_follows_s1, clk, arst_n, vld_s2, $past(vld_s1), "compare stage valid without a read")
	`TDT_ASSERT_SAME(a_write_ptr_behind, clk, arst_n, 1'b1, j_q <= idx_q, "compaction pointer ahead of the read pointer")
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the touch drag tracker: directed and random drag traffic against a scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAGS = tdt_pkg::MAX_DRAGS_DEF;
	localparam int BTN_W = tdt_pkg::BUTTON_BITS_DEF;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int IDLE_LIMIT = 2000;
	localparam int PRINT_LIMIT = 60;

	localparam logic [tdt_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [tdt_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [tdt_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

	localparam logic [tdt_pkg::PADDR_W-1:0] ADDR_MAX_DIST = {tdt_pkg::REG_MAX_DIST, 2'b00};
	localparam logic [tdt_pkg::PADDR_W-1:0] ADDR_SPARE = {~tdt_pkg::REG_MAX_DIST, 2'b00};

	typedef logic signed [tdt_pkg::COORD_BITS_DEF-1:0] coord_t;

	typedef struct {
		logic [tdt_pkg::CMD_W-1:0] command;
		coord_t                    prev_x;
		coord_t                    prev_y;
		coord_t                    pos_x;
		coord_t                    pos_y;
		logic                      touch_down;
		logic [BTN_W-1:0]          btn_mask;
		logic                      ui_flag;
		logic [IDX_W-1:0]          read_index;
	} drag_req_t;

	typedef struct {
		logic [IDX_W-1:0] slot;
		logic             created;
		logic             table_full;
		logic [CNT_W-1:0] drag_count;
		coord_t           entry_x;
		coord_t           entry_y;
		coord_t           entry_start_x;
		coord_t           entry_start_y;
		logic             entry_pressed;
		logic             entry_new;
		logic [BTN_W-1:0] entry_mask;
		logic             entry_ui;
	} drag_rsp_t;

	// Mirror of the drag table; each accepted command yields one expected result beat.
	class drag_scoreboard;
		coord_t last_x[DRAGS];
		coord_t last_y[DRAGS];
		coord_t start_x[DRAGS];
		coord_t start_y[DRAGS];
		logic held[DRAGS];
		logic fresh[DRAGS];
		logic ui[DRAGS];
		logic [BTN_W-1:0] mask[DRAGS];
		int total;
		logic [tdt_pkg::DIST_W-1:0] max_dist;
		drag_rsp_t pending_q[$];
		int errors;

		function new();
			total = 0;
			max_dist = tdt_pkg::DIST_RESET;
			errors = 0;
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function int manhattan(input coord_t ax, input coord_t ay, input coord_t bx,
				input coord_t by);
			int dx;
			int dy;
			dx = int'(ax) - int'(bx);
			dy = int'(ay) - int'(by);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			return dx + dy;
		endfunction

		function void note_request(input drag_req_t r);
			drag_rsp_t e;
			int i;
			int j;
			int d;
			int best;
			int best_d;
			logic found;
			e = '{default: 0};
			case (r.command)
				tdt_pkg::CMD_UPDATE: begin
					found = 1'b0;
					best = 0;
					best_d = 0;
					for (i = 0; i < total; i++) begin
						d = manhattan(last_x[i], last_y[i], r.prev_x, r.prev_y);
						if (!found || d < best_d) begin
							found = 1'b1;
							best_d = d;
							best = i;
						end
					end
					if (found && (!r.touch_down || best_d <= int'(max_dist))) begin
						fresh[best] = 1'b0;
						last_x[best] = r.pos_x;
						last_y[best] = r.pos_y;
						held[best] = r.touch_down;
						mask[best] = r.btn_mask;
						e.slot = IDX_W'(best);
					end else if (total < DRAGS) begin
						start_x[total] = r.pos_x;
						start_y[total] = r.pos_y;
						last_x[total] = r.pos_x;
						last_y[total] = r.pos_y;
						held[total] = r.touch_down;
						fresh[total] = 1'b1;
						mask[total] = r.btn_mask;
						ui[total] = 1'b0;
						e.slot = IDX_W'(total);
						e.created = 1'b1;
						total++;
					end else begin
						e.table_full = 1'b1;
					end
				end
				tdt_pkg::CMD_DROP: begin
					j = 0;
					for (i = 0; i < total; i++) begin
						if (held[i]) begin
							last_x[j] = last_x[i];
							last_y[j] = last_y[i];
							start_x[j] = start_x[i];
							start_y[j] = start_y[i];
							held[j] = held[i];
							fresh[j] = fresh[i];
							mask[j] = mask[i];
							ui[j] = ui[i];
							j++;
						end
					end
					total = j;
				end
				tdt_pkg::CMD_CLEAR: total = 0;
				tdt_pkg::CMD_SET_UI: begin
					for (i = 0; i < total; i++)
						ui[i] = r.ui_flag;
				end
				tdt_pkg::CMD_READ: begin
					e.slot = r.read_index;
					if (int'(r.read_index) < total) begin
						e.entry_x = last_x[r.read_index];
						e.entry_y = last_y[r.read_index];
						e.entry_start_x = start_x[r.read_index];
						e.entry_start_y = start_y[r.read_index];
						e.entry_pressed = held[r.read_index];
						e.entry_new = fresh[r.read_index];
						e.entry_mask = mask[r.read_index];
						e.entry_ui = ui[r.read_index];
					end
				end
				default: ;
			endcase
			e.drag_count = CNT_W'(total);
			pending_q = {pending_q, e};
		endfunction

		task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
			if (got !== want)
				report($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_response(input drag_rsp_t got);
			drag_rsp_t w;
			if (pending_q.size() == 0) begin
				report("result beat arrived with no command outstanding");
				return;
			end
			w = pending_q.pop_front();
			compare_field("slot", got.slot, w.slot);
			compare_field("created", got.created, w.created);
			compare_field("table_full", got.table_full, w.table_full);
			compare_field("drag_count", got.drag_count, w.drag_count);
			compare_field("entry_x", got.entry_x, w.entry_x);
			compare_field("entry_y", got.entry_y, w.entry_y);
			compare_field("entry_start_x", got.entry_start_x, w.entry_start_x);
			compare_field("entry_start_y", got.entry_start_y, w.entry_start_y);
			compare_field("entry_pressed", got.entry_pressed, w.entry_pressed);
			compare_field("entry_new", got.entry_new, w.entry_new);
			compare_field("entry_mask", got.entry_mask, w.entry_mask);
			compare_field("entry_ui", got.entry_ui, w.entry_ui);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tdt_pkg::PADDR_W-1:0] paddr;
	logic [tdt_pkg::PDATA_W-1:0] pwdata;
	logic [tdt_pkg::PDATA_W-1:0] prdata;
	logic pready;

	tdt_req_if #(.IDX_W(IDX_W)) req ();
	tdt_rsp_if #(.IDX_W(IDX_W), .CNT_W(CNT_W)) rsp ();

	touch_drag_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req),
		.rsp(rsp)
	);

	drag_scoreboard sb = new();
	int burst_left = 0;
	int idle_cycles = 0;
	int rx_mode = 0;
	int rx_timer = 0;
	int rx_hold = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: modes of steady ready, random ready and occasional long stalls.
	always @(posedge clk) begin
		if (rx_timer == 0) begin
			rx_mode <= $urandom_range(2);
			rx_timer <= $urandom_range(20, 200);
		end else begin
			rx_timer <= rx_timer - 1;
		end
		if (rx_hold != 0) begin
			rsp.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			case (rx_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(3) != 0);
				default: begin
					rsp.ready <= 1'b1;
					if ($urandom_range(9) == 0)
						rx_hold <= $urandom_range(1, 24);
				end
			endcase
		end
	end

	always @(posedge clk) begin : result_monitor
		drag_rsp_t got;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got.slot = rsp.slot;
			got.created = rsp.created;
			got.table_full = rsp.table_full;
			got.drag_count = rsp.drag_count;
			got.entry_x = rsp.entry_x;
			got.entry_y = rsp.entry_y;
			got.entry_start_x = rsp.entry_start_x;
			got.entry_start_y = rsp.entry_start_y;
			got.entry_pressed = rsp.entry_pressed;
			got.entry_new = rsp.entry_new;
			got.entry_mask = rsp.entry_mask;
			got.entry_ui = rsp.entry_ui;
			sb.check_response(got);
		end
	end

	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Each transfer ends by returning the bus to idle.
	task automatic apb_write(input logic [tdt_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [tdt_pkg::PADDR_W-1:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for the table to go quiet, writes the spare address, then changes the distance threshold and reads it back.
	task automatic set_threshold(input logic [31:0] value);
		logic [31:0] rd;
		req.valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		apb_write(ADDR_SPARE, $urandom);
		apb_write(ADDR_MAX_DIST, value);
		sb.max_dist = value[tdt_pkg::DIST_W-1:0];
		apb_read(ADDR_MAX_DIST, rd);
		if (rd !== 32'(sb.max_dist))
			sb.report($sformatf("threshold reads %0h, expected %0h", rd, sb.max_dist));
	endtask

	// Sends one command beat, with a random gap whenever a burst runs out.
	task automatic issue(input drag_req_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 14);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.command <= it.command;
		req.prev_x <= it.prev_x;
		req.prev_y <= it.prev_y;
		req.pos_x <= it.pos_x;
		req.pos_y <= it.pos_y;
		req.touch_down <= it.touch_down;
		req.btn_mask <= it.btn_mask;
		req.ui_flag <= it.ui_flag;
		req.read_index <= it.read_index;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(it);
	endtask

	function automatic drag_req_t mk(input logic [tdt_pkg::CMD_W-1:0] cmd, input int px,
			input int py, input int nx, input int ny, input logic pr,
			input logic [BTN_W-1:0] bm, input logic uf, input int idx);
		drag_req_t it;
		it.command = cmd;
		it.prev_x = coord_t'(px);
		it.prev_y = coord_t'(py);
		it.pos_x = coord_t'(nx);
		it.pos_y = coord_t'(ny);
		it.touch_down = pr;
		it.btn_mask = bm;
		it.ui_flag = uf;
		it.read_index = IDX_W'(idx);
		return it;
	endfunction

	// Most updates aim near a live drag so that continuation, the threshold edge
	// and ties are hit often; the rest are scattered points and other commands.
	function automatic drag_req_t gen_item();
		drag_req_t it;
		int r;
		int k;
		int dx;
		int dy;
		it.command = tdt_pkg::CMD_UPDATE;
		it.prev_x = coord_t'($urandom);
		it.prev_y = coord_t'($urandom);
		it.pos_x = coord_t'($urandom);
		it.pos_y = coord_t'($urandom);
		it.touch_down = 1'($urandom_range(1));
		it.btn_mask = BTN_W'($urandom);
		it.ui_flag = 1'($urandom_range(1));
		it.read_index = IDX_W'($urandom);
		r = $urandom_range(99);
		if (r < 56) begin
			it.touch_down = ($urandom_range(4) != 0);
			if (sb.total > 0 && $urandom_range(9) < 7) begin
				k = $urandom_range(sb.total - 1);
				case ($urandom_range(3))
					0: begin
						dx = $urandom_range(4);
						dy = $urandom_range(4);
					end
					1: begin
						dx = $urandom_range(300);
						dy = $urandom_range(300);
					end
					2: begin
						if (sb.max_dist <= 65535) begin
							dx = $urandom_range(int'(sb.max_dist));
							dy = int'(sb.max_dist) - dx + $urandom_range(1);
						end else begin
							dx = $urandom_range(32767);
							dy = $urandom_range(32767);
						end
					end
					default: begin
						dx = $urandom_range(3000);
						dy = $urandom_range(3000);
					end
				endcase
				if ($urandom_range(1)) dx = -dx;
				if ($urandom_range(1)) dy = -dy;
				it.prev_x = sb.last_x[k] + coord_t'(dx);
				it.prev_y = sb.last_y[k] + coord_t'(dy);
			end else if ($urandom_range(1)) begin
				it.prev_x = coord_t'(int'($urandom_range(2000)) - 1000);
				it.prev_y = coord_t'(int'($urandom_range(2000)) - 1000);
			end
			if ($urandom_range(3) != 0) begin
				it.pos_x = it.prev_x + coord_t'(int'($urandom_range(100)) - 50);
				it.pos_y = it.prev_y + coord_t'(int'($urandom_range(100)) - 50);
			end
		end else if (r < 76) begin
			it.command = tdt_pkg::CMD_READ;
			if (sb.total > 0 && $urandom_range(3) != 0)
				it.read_index = IDX_W'($urandom_range(sb.total - 1));
		end else if (r < 84) begin
			it.command = tdt_pkg::CMD_DROP;
		end else if (r < 86) begin
			it.command = tdt_pkg::CMD_CLEAR;
		end else if (r < 94) begin
			it.command = tdt_pkg::CMD_SET_UI;
		end else begin
			it.command = tdt_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		return it;
	endfunction

	initial begin
		int phase;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req.valid <= 1'b0;
		req.command <= tdt_pkg::CMD_UPDATE;
		req.prev_x <= '0;
		req.prev_y <= '0;
		req.pos_x <= '0;
		req.pos_y <= '0;
		req.touch_down <= 1'b0;
		req.btn_mask <= '0;
		req.ui_flag <= 1'b0;
		req.read_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold.
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_UPDATE, 0, 0, -32768, 32767, 1, 8'hff, 0, 0));
		issue(mk(tdt_pkg::CMD_UPDATE, -32768, 32767, 32767, -32768, 1, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_UPDATE, 0, 0, 0, 0, 1, 8'h55, 0, 0));
		// Exactly at the threshold, then one past it.
		issue(mk(tdt_pkg::CMD_UPDATE, 50, 56, 1, 1, 1, 8'haa, 0, 0));
		issue(mk(tdt_pkg::CMD_UPDATE, 108, 1, 201, 1, 1, 8'h01, 0, 0));
		// Equal distance to two drags: the earlier one must win.
		issue(mk(tdt_pkg::CMD_UPDATE, 101, 1, 101, 5, 1, 8'h02, 0, 0));
		issue(mk(tdt_pkg::CMD_SET_UI, 0, 0, 0, 0, 0, 8'h00, 1, 0));
		issue(mk(tdt_pkg::CMD_UPDATE, 20000, -20000, 20000, -20000, 1, 8'h80, 0, 0));
		// Releases continue the nearest drag however far it is.
		issue(mk(tdt_pkg::CMD_UPDATE, 32767, 32767, 32767, 32767, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_UPDATE, 101, 5, 101, 5, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 1));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 2));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 3));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 15));
		issue(mk(tdt_pkg::CMD_DROP, 0, 0, 0, 0, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 1));
		issue(mk(CMD_SPARE_LO, -1, -1, -1, -1, 1, 8'hff, 1, 15));
		issue(mk(CMD_SPARE_MID, 0, 0, 0, 0, 1, 8'h00, 1, 0));
		issue(mk(CMD_SPARE_HI, 0, 0, 0, 0, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_SET_UI, 0, 0, 0, 0, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 8'h00, 0, 0));
		issue(mk(tdt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'h00, 0, 0));

		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				1: set_threshold(32'd0);
				2: set_threshold({15'($urandom), 17'h1ffff});
				3: set_threshold($urandom_range(1, 400));
				4: set_threshold(32'(tdt_pkg::DIST_RESET));
				5: set_threshold({15'($urandom), 17'($urandom)});
				6: set_threshold($urandom_range(50, 3000));
				default: ;
			endcase
			repeat ((phase == 0) ? 100 : 115) issue(gen_item());
		end

		req.valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### touch_drag_tracker.f
+incdir+sv
sv/tdt_pkg.sv
sv/tdt_req_if.sv
sv/tdt_rsp_if.sv
sv/tdt_ram.sv
sv/tdt_regs.sv
sv/tdt_ctrl.sv
sv/tdt_dp.sv
sv/touch_drag_tracker.sv
tb/sv/tb_top.sv
